>>> rtl/gsf_pkg.sv
// Shared types, constants and control records for the Gaussian smoothing FIR.
package gsf_pkg;

    // Default build settings
    localparam int MAX_HALF_DEF       = 16;
    localparam int COEF_FRAC_BITS_DEF = 15;

    // Register and counter constants
    localparam logic [4:0] HALF_RESET = 5'd13;
    localparam logic [5:0] SEEN_MAX   = 6'd63;

    // Request codes
    typedef enum logic {
        REQ_COEF   = 1'b0,
        REQ_SAMPLE = 1'b1
    } t_req;

    // Input transfer
    typedef struct packed {
        t_req               req_type;
        logic [4:0]         coef_index;
        logic [15:0]        coef_value;
        logic signed [15:0] sample;
        logic               last;
    } t_in;

    // Output transfer
    typedef struct packed {
        logic signed [15:0] filtered;
        logic               last_out;
    } t_out;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_TAP,
        S_DRAIN,
        S_OUT
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic accept;   // input transfer taken this cycle
        logic tap;      // issue one tap read
        logic finish;   // round and load the output register
        logic take;     // output transfer done this cycle
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic emit;     // the offered item produces at least one output
        logic tap_end;  // current tap is the last one
        logic busy;     // multiply pipeline still holds taps
        logic more;     // further flush outputs remain after this one
    } t_stat;

endpackage

>>> rtl/gsf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gsf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 33
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/gsf_ctrl.sv
// Controller state machine: sequences taps, drain, rounding and output transfers.
module gsf_ctrl
    import gsf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_stat.emit) begin
                    n_state = S_TAP;
                end
            end
            S_TAP: begin
                if (i_stat.tap_end) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_stat.busy) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = i_stat.more ? S_TAP : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs and commands
    always_comb begin
        o_in_ready   = 1'b0;
        o_out_valid  = 1'b0;
        o_cmd        = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            S_TAP: begin
                o_cmd.tap = 1'b1;
            end
            S_DRAIN: begin
                o_cmd.finish = !i_stat.busy;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                o_cmd.take  = i_out_ready;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

>>> rtl/gsf_datapath.sv
// Datapath: sample and coefficient stores, tap addressing, shared MAC, rounding.
module gsf_datapath
    import gsf_pkg::*;
#(
    parameter int MAX_HALF       = MAX_HALF_DEF,
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [4:0] i_cfg_data,
    input  t_in        i_in_data,
    input  t_cmd       i_cmd,
    output t_stat      o_stat,
    output t_out       o_out_data
);

    localparam int DEPTH  = 2 * MAX_HALF + 1;
    localparam int DW     = $clog2(DEPTH);
    localparam int HW     = $clog2(MAX_HALF + 1);
    localparam int KW     = HW + 1;
    localparam int DSW    = DW + 1;
    localparam int PROD_W = 33;
    localparam int ACC_W  = PROD_W + $clog2(DEPTH);
    localparam int RW     = ACC_W + 1;
    localparam logic signed [RW-1:0] RND    = RW'(1) <<< (COEF_FRAC_BITS - 1);
    localparam logic signed [RW-1:0] SAT_HI = RW'(32767);
    localparam logic signed [RW-1:0] SAT_LO = RW'(-32768);

    // Control registers
    logic [4:0]              r_half;
    logic [5:0]              r_seen;
    logic [DW-1:0]           r_wptr;
    logic                    r_v1;
    logic                    r_v2;
    // Per-output working registers
    logic [HW-1:0]           r_h;
    logic [HW-1:0]           r_m;
    logic signed [KW-1:0]    r_k;
    logic [DW-1:0]           r_ilim;
    logic                    r_blk_last;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0] r_acc;
    t_out                    r_out;

    logic [DW-1:0]           n_wptr;
    logic [HW-1:0]           w_h_cfg;
    logic                    w_is_sample;
    logic                    w_sample_we;
    logic                    w_coef_we;
    logic [HW-1:0]           w_m_init;
    logic [DW-1:0]           w_ilim;
    logic signed [KW-1:0]    w_k_init;
    logic signed [DSW-1:0]   w_d;
    logic signed [DSW-1:0]   w_ilim_s;
    logic [DW-1:0]           w_dc;
    logic [DW:0]             w_wrap;
    logic [DW-1:0]           w_win_addr;
    logic signed [KW-1:0]    w_kneg;
    logic [HW-1:0]           w_coef_addr;
    logic [15:0]             w_win_rd;
    logic [15:0]             w_coef_rd;
    logic signed [RW-1:0]    w_rnd;
    logic signed [RW-1:0]    w_q;
    logic signed [15:0]      w_sat;

    // Decode the offered item
    assign w_h_cfg     = (r_half > 5'(MAX_HALF)) ? HW'(MAX_HALF) : r_half[HW-1:0];
    assign w_is_sample = (i_in_data.req_type == REQ_SAMPLE);
    assign w_sample_we = i_cmd.accept && w_is_sample;
    assign w_coef_we   = i_cmd.accept && !w_is_sample
                         && (i_in_data.coef_index <= 5'(MAX_HALF));
    assign w_m_init    = (i_in_data.last && (r_seen < 6'(w_h_cfg))) ?
                         r_seen[HW-1:0] : w_h_cfg;
    assign w_ilim      = (r_seen > 6'(DEPTH - 1)) ? DW'(DEPTH - 1) : r_seen[DW-1:0];
    assign w_k_init    = -$signed(KW'(w_h_cfg));
    assign n_wptr      = (r_wptr == DW'(DEPTH - 1)) ? '0 : r_wptr + DW'(1);

    // Status to the controller
    assign o_stat.emit    = w_is_sample && (i_in_data.last || (r_seen >= 6'(w_h_cfg)));
    assign o_stat.tap_end = (r_k == $signed(KW'(r_h)));
    assign o_stat.busy    = r_v1 || r_v2;
    assign o_stat.more    = r_blk_last && (r_m != '0);

    // Window distance of the current tap, held inside the block
    assign w_d      = $signed(DSW'(r_m)) - DSW'(r_k);
    assign w_ilim_s = $signed(DSW'(r_ilim));
    always_comb begin
        if (w_d < 0) begin
            w_dc = '0;
        end else if (w_d > w_ilim_s) begin
            w_dc = r_ilim;
        end else begin
            w_dc = w_d[DW-1:0];
        end
    end

    // Circular address, newest sample at the write pointer
    assign w_wrap     = (DW + 1)'(r_wptr) + (DW + 1)'(DEPTH) - (DW + 1)'(w_dc);
    assign w_win_addr = (r_wptr >= w_dc) ? (r_wptr - w_dc) : w_wrap[DW-1:0];

    // Coefficient address is the tap distance from center
    assign w_kneg      = -r_k;
    assign w_coef_addr = r_k[KW-1] ? w_kneg[HW-1:0] : r_k[HW-1:0];

    gsf_ram #(
        .WIDTH (16),
        .DEPTH (DEPTH)
    ) u_win_ram (
        .i_clk   (i_clk),
        .i_we    (w_sample_we),
        .i_waddr (n_wptr),
        .i_wdata (i_in_data.sample),
        .i_raddr (w_win_addr),
        .o_rdata (w_win_rd)
    );

    gsf_ram #(
        .WIDTH (16),
        .DEPTH (MAX_HALF + 1)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (w_coef_we),
        .i_waddr (i_in_data.coef_index[HW-1:0]),
        .i_wdata (i_in_data.coef_value),
        .i_raddr (w_coef_addr),
        .o_rdata (w_coef_rd)
    );

    // Configuration, block position and pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half <= HALF_RESET;
            r_seen <= '0;
            r_wptr <= '0;
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_half <= i_cfg_data;
            end
            if (w_sample_we) begin
                r_wptr <= n_wptr;
                if (i_in_data.last) begin
                    r_seen <= '0;
                end else if (r_seen != SEEN_MAX) begin
                    r_seen <= r_seen + 6'd1;
                end
            end
            r_v1 <= i_cmd.tap;
            r_v2 <= r_v1;
        end
    end

    // Tap sequencing and output centre
    always_ff @(posedge i_clk) begin
        if (w_sample_we) begin
            r_h        <= w_h_cfg;
            r_m        <= w_m_init;
            r_k        <= w_k_init;
            r_ilim     <= w_ilim;
            r_blk_last <= i_in_data.last;
        end else if (i_cmd.take) begin
            r_m <= r_m - HW'(1);
            r_k <= -$signed(KW'(r_h));
        end else if (i_cmd.tap) begin
            r_k <= r_k + KW'(1);
        end
    end

    // Multiply, then accumulate
    always_ff @(posedge i_clk) begin
        r_prod <= $signed(w_win_rd) * $signed({1'b0, w_coef_rd});
        if (w_sample_we || i_cmd.take) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    // Round half up, floor, saturate to 16 bits
    assign w_rnd = RW'(r_acc) + RND;
    assign w_q   = w_rnd >>> COEF_FRAC_BITS;
    always_comb begin
        if (w_q > SAT_HI) begin
            w_sat = 16'sh7fff;
        end else if (w_q < SAT_LO) begin
            w_sat = -16'sh8000;
        end else begin
            w_sat = w_q[15:0];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out.filtered <= w_sat;
            r_out.last_out <= r_blk_last && (r_m == '0);
        end
    end

    assign o_out_data = r_out;

endmodule

>>> rtl/gaussian_smoothing_fir.sv
// Top level of the Gaussian smoothing FIR: controller plus datapath.
//
// Input channel (i_in_valid / o_in_ready, payload i_in_data) carries either a
// coefficient load (by distance from centre) or one sample of a block; the
// sample flagged last ends the block. Output channel (o_out_valid /
// i_out_ready, payload o_out_data) carries smoothed samples, last_out set on
// the block's final output. half_width is written through i_cfg_we/i_cfg_data.
// One shared multiply-accumulate walks the 2h+1 taps, one tap per cycle, reading
// the circular sample RAM and the coefficient RAM. Each tap passes the RAM read,
// product and accumulator registers; once they drain, the rounded sum is loaded
// into the output register and output valid rises. The next item is taken the
// cycle after that output transfers, so no sample is taken while one is in work.
// A coefficient load, or a sample that completes no output, starts no taps.
// The final sample of a block flushes up to h+1 outputs. Reset sets half_width
// to 13 and starts a new block; coefficients must be loaded before use. While
// the receiver stalls the output holds and no new input is taken.
module gaussian_smoothing_fir
    import gsf_pkg::*;
#(
    parameter int MAX_HALF       = MAX_HALF_DEF,
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [4:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in        i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out       o_out_data
);

    t_cmd  w_cmd;
    t_stat w_stat;

    gsf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    gsf_datapath #(
        .MAX_HALF       (MAX_HALF),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in_data  (i_in_data),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .o_out_data (o_out_data)
    );

endmodule
